// ===== hw/rtl/char_lcd_nibble_write_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_macros.svh
// Assertion macros used by the LCD write sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent true in the same cycle.
`define LCDNW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdnw assertion failed");

// Antecedent true implies consequent true in the next cycle.
`define LCDNW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdnw assertion failed");

`else

`define LCDNW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCDNW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, codes, hold times and sequence tables for the LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    localparam int HOLD_W      = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request kinds
    typedef enum logic [2:0] {
        KIND_CMD   = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_INIT  = 3'd2,
        KIND_LINE1 = 3'd3,
        KIND_LINE2 = 3'd4
    } kind_t;

    // Hold times in microseconds
    localparam logic [HOLD_W-1:0] HOLD_NONE      = 13'd0;
    localparam logic [HOLD_W-1:0] HOLD_STROBE    = 13'd2;
    localparam logic [HOLD_W-1:0] HOLD_GAP       = 13'd2;
    localparam logic [HOLD_W-1:0] HOLD_BYTE      = 13'd50;
    localparam logic [HOLD_W-1:0] HOLD_PAUSE     = 13'd5050;
    localparam logic [HOLD_W-1:0] HOLD_WAKE_HIGH = 13'd100;
    localparam logic [HOLD_W-1:0] HOLD_WAKE_LOW  = 13'd5000;

    // Display command codes
    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_DDRAM_LINE1 = 8'h80;
    localparam logic [7:0] CMD_DDRAM_LINE2 = 8'hC0;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [3:0] NIB_ZERO  = 4'h0;

    // Sequence limits
    localparam logic [3:0] WAKE_LAST_IDX = 4'd10;
    localparam logic [2:0] BYTE_LAST_POS = 3'd5;
    localparam logic [2:0] INIT_LAST_CMD = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAKE,
        ST_BYTE
    } seq_state_t;

    // One queued job for the back end
    typedef struct packed {
        logic       init;
        logic       rs;
        logic       long_hold;
        logic [7:0] byte_value;
    } job_t;

    // One port write
    typedef struct packed {
        logic [3:0]        nibble;
        logic              reg_select;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } wr_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        c = CMD_DDRAM_LINE1;
        case (idx)
            3'd0:    c = CMD_HOME;
            3'd1:    c = CMD_FUNC_4BIT;
            3'd2:    c = CMD_DISPLAY_ON;
            3'd3:    c = CMD_ENTRY_MODE;
            3'd4:    c = CMD_CLEAR;
            default: c = CMD_DDRAM_LINE1;
        endcase
        return c;
    endfunction

    // Wake-up part of the init sequence, eleven writes
    function automatic wr_t wake_write(input logic [3:0] idx);
        wr_t w;
        w = '0;
        case (idx)
            4'd0:    w.nibble = NIB_ZERO;
            4'd1:    w.nibble = NIB_WAKE;
            4'd2, 4'd4, 4'd6:
            begin
                w.nibble  = NIB_WAKE;
                w.enable  = 1'b1;
                w.hold_us = HOLD_WAKE_HIGH;
            end
            4'd3, 4'd5, 4'd7:
            begin
                w.nibble  = NIB_WAKE;
                w.hold_us = HOLD_WAKE_LOW;
            end
            4'd8:    w.nibble = NIB_4BIT;
            4'd9:
            begin
                w.nibble  = NIB_4BIT;
                w.enable  = 1'b1;
                w.hold_us = HOLD_WAKE_HIGH;
            end
            default:
            begin
                w.nibble  = NIB_4BIT;
                w.hold_us = HOLD_WAKE_LOW;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_write_sequencer_if.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_if
// Valid/ready channels for requests and for LCD port writes.
// ----------------------------------------------------------------------------
interface lcdnw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [3:0] column;

    modport source (output valid, output kind, output byte_value, output column,
                    input ready);
    modport sink   (input valid, input kind, input byte_value, input column,
                    output ready);
endinterface

interface lcdnw_wr_if;
    logic        valid;
    logic        ready;
    logic [3:0]  nibble;
    logic        reg_select;
    logic        enable;
    logic [12:0] hold_us;
    logic        last;

    modport source (output valid, output nibble, output reg_select, output enable,
                    output hold_us, output last, input ready);
    modport sink   (input valid, input nibble, input reg_select, input enable,
                    input hold_us, input last, output ready);
endinterface

// ===== hw/rtl/lcdnw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdnw_queue
// Short job queue between the request decoder and the write sequencer.
// ----------------------------------------------------------------------------
module lcdnw_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdnw_pkg::job_t     push_job,
    input  logic                pop,
    output lcdnw_pkg::job_t     head,
    output lcdnw_pkg::q_status_t status
);

    lcdnw_pkg::job_t                   entry_reg [lcdnw_pkg::QUEUE_DEPTH];
    logic [lcdnw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [lcdnw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [lcdnw_pkg::QCNT_W-1:0]      count_reg;
    logic [lcdnw_pkg::QCNT_W-1:0]      count_next;
    logic                              do_push;
    logic                              do_pop;

    assign status.full  = (count_reg == lcdnw_pkg::QCNT_W'(lcdnw_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/lcdnw_front.sv =====
// ----------------------------------------------------------------------------
// lcdnw_front
// Request decoder: accepts requests and turns each into a sequencer job.
// ----------------------------------------------------------------------------
module lcdnw_front
(
    lcdnw_req_if.sink            req,
    input  lcdnw_pkg::q_status_t status,
    output logic                 push,
    output lcdnw_pkg::job_t      push_job
);

    logic known;

    assign req.ready = !status.full;

    always_comb
    begin
        push_job = '0;
        known    = 1'b1;
        unique case (req.kind)
            lcdnw_pkg::KIND_CMD:
            begin
                push_job.byte_value = req.byte_value;
            end
            lcdnw_pkg::KIND_DATA:
            begin
                push_job.rs         = 1'b1;
                push_job.byte_value = req.byte_value;
            end
            lcdnw_pkg::KIND_INIT:
            begin
                push_job.init      = 1'b1;
                push_job.long_hold = 1'b1;
            end
            lcdnw_pkg::KIND_LINE1:
            begin
                push_job.long_hold  = 1'b1;
                push_job.byte_value = lcdnw_pkg::CMD_DDRAM_LINE1 | {4'h0, req.column};
            end
            lcdnw_pkg::KIND_LINE2:
            begin
                push_job.long_hold  = 1'b1;
                push_job.byte_value = lcdnw_pkg::CMD_DDRAM_LINE2 | {4'h0, req.column};
            end
            default:
            begin
                // drop undefined kinds: the transaction completes with no writes
                known = 1'b0;
            end
        endcase
    end

    assign push = req.valid && req.ready && known;

endmodule

// ===== hw/rtl/lcdnw_back.sv =====
// ----------------------------------------------------------------------------
// lcdnw_back
// Write sequencer: steps through each job and emits one port write a cycle while the port is ready.
// ----------------------------------------------------------------------------
module lcdnw_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcdnw_pkg::job_t      head,
    input  lcdnw_pkg::q_status_t status,
    output logic                 pop,
    lcdnw_wr_if.source           wr
);

    lcdnw_pkg::seq_state_t state_reg, state_next;
    lcdnw_pkg::job_t       job_reg, job_next;
    logic [3:0]            wake_idx_reg, wake_idx_next;
    logic [2:0]            pos_reg, pos_next;
    logic [2:0]            cmd_idx_reg, cmd_idx_next;
    logic                  out_valid_reg, out_valid_next;
    lcdnw_pkg::wr_t        out_reg, out_next;

    lcdnw_pkg::wr_t        cur;
    logic [7:0]            byte_cur;
    logic [3:0]            nib_cur;
    logic                  adv;
    logic                  emit;
    logic                  load;

    assign adv = !out_valid_reg || wr.ready;

    // Current write
    always_comb
    begin
        cur      = '0;
        byte_cur = job_reg.init ? lcdnw_pkg::init_cmd(cmd_idx_reg) : job_reg.byte_value;
        nib_cur  = (pos_reg < 3'd3) ? byte_cur[7:4] : byte_cur[3:0];
        if (state_reg == lcdnw_pkg::ST_WAKE)
        begin
            cur = lcdnw_pkg::wake_write(wake_idx_reg);
        end
        else
        begin
            cur.nibble     = nib_cur;
            cur.reg_select = job_reg.rs;
            case (pos_reg)
                3'd1, 3'd4:
                begin
                    cur.enable  = 1'b1;
                    cur.hold_us = lcdnw_pkg::HOLD_STROBE;
                end
                3'd2:
                begin
                    cur.hold_us = lcdnw_pkg::HOLD_GAP;
                end
                3'd5:
                begin
                    cur.hold_us = job_reg.long_hold ? lcdnw_pkg::HOLD_PAUSE
                                                    : lcdnw_pkg::HOLD_BYTE;
                    cur.last    = !job_reg.init || (cmd_idx_reg == lcdnw_pkg::INIT_LAST_CMD);
                end
                default:
                begin
                    cur.hold_us = lcdnw_pkg::HOLD_NONE;
                end
            endcase
        end
    end

    assign emit = adv && (state_reg != lcdnw_pkg::ST_IDLE);
    assign load = adv && !status.empty
                  && ((state_reg == lcdnw_pkg::ST_IDLE) || (emit && cur.last));
    assign pop  = load;

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        wake_idx_next  = wake_idx_reg;
        pos_next       = pos_reg;
        cmd_idx_next   = cmd_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (adv)
        begin
            out_valid_next = emit;
            out_next       = cur;
        end

        unique case (state_reg)
            lcdnw_pkg::ST_IDLE:
            begin
            end
            lcdnw_pkg::ST_WAKE:
            begin
                if (emit)
                begin
                    if (wake_idx_reg == lcdnw_pkg::WAKE_LAST_IDX)
                    begin
                        state_next   = lcdnw_pkg::ST_BYTE;
                        pos_next     = '0;
                        cmd_idx_next = '0;
                    end
                    else
                    begin
                        wake_idx_next = wake_idx_reg + 1'b1;
                    end
                end
            end
            lcdnw_pkg::ST_BYTE:
            begin
                if (emit)
                begin
                    if (cur.last)
                    begin
                        state_next = lcdnw_pkg::ST_IDLE;
                    end
                    else if (pos_reg == lcdnw_pkg::BYTE_LAST_POS)
                    begin
                        pos_next     = '0;
                        cmd_idx_next = cmd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lcdnw_pkg::ST_IDLE;
            end
        endcase

        // start the next job straight after the last write of this one
        if (load)
        begin
            job_next      = head;
            state_next    = head.init ? lcdnw_pkg::ST_WAKE : lcdnw_pkg::ST_BYTE;
            wake_idx_next = '0;
            pos_next      = '0;
            cmd_idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdnw_pkg::ST_IDLE;
            wake_idx_reg  <= '0;
            pos_reg       <= '0;
            cmd_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wake_idx_reg  <= wake_idx_next;
            pos_reg       <= pos_next;
            cmd_idx_reg   <= cmd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign wr.valid      = out_valid_reg;
    assign wr.nibble     = out_reg.nibble;
    assign wr.reg_select = out_reg.reg_select;
    assign wr.enable     = out_reg.enable;
    assign wr.hold_us    = out_reg.hold_us;
    assign wr.last       = out_reg.last;

endmodule

// ===== hw/rtl/char_lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD 4-bit bus controller: turns requests into ordered port writes.
// ----------------------------------------------------------------------------
// Path: a request is pushed into the job queue, then loaded into the write
// sequencer, whose first write is registered at the output. Throughput: one
// port write per cycle while the port is ready; the write sequencer sets the rate,
// and requests queue ahead. Undefined kinds are accepted and produce no writes.
// Reset: asynchronous; empties the job queue, idles the sequencer, drops valid.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_sequencer_macros.svh"

module char_lcd_nibble_write_sequencer
(
    input  logic       clk,
    input  logic       rst_n,
    lcdnw_req_if.sink  req,
    lcdnw_wr_if.source wr
);

    lcdnw_pkg::job_t      push_job;
    lcdnw_pkg::job_t      head;
    lcdnw_pkg::q_status_t status;
    logic                 push;
    logic                 pop;

    lcdnw_front u_front
    (
        .req      (req),
        .status   (status),
        .push     (push),
        .push_job (push_job)
    );

    lcdnw_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    lcdnw_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .status (status),
        .pop    (pop),
        .wr     (wr)
    );

    // Strobe writes never end a request
    `LCDNW_ASSERT_IMP(a_strobe_not_last, clk, rst_n, wr.valid && wr.enable, !wr.last)

    // Enable high holds only for a strobe or wake-high time
    `LCDNW_ASSERT_IMP(a_strobe_hold, clk, rst_n, wr.valid && wr.enable,
        wr.hold_us == lcdnw_pkg::HOLD_STROBE || wr.hold_us == lcdnw_pkg::HOLD_WAKE_HIGH)

    // Never pop an empty queue
    `LCDNW_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !status.empty)

    // A push without a pop leaves the queue non-empty
    `LCDNW_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !status.empty)

endmodule
